// ===== hw/rtl/error_trend_gain_rule_tuner_assert.svh =====
// Assertion macros used by the tuner's port checker.
`ifndef ERROR_TREND_GAIN_RULE_TUNER_ASSERT_SVH
`define ERROR_TREND_GAIN_RULE_TUNER_ASSERT_SVH

// Same-cycle implication, disabled while dis is true.
`define ETGRT_ASSERT_NOW(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while dis is true.
`define ETGRT_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/etgrt_pkg.sv =====
// Shared types and constants for the error trend gain rule tuner.
package etgrt_pkg;

  // request tags
  typedef enum logic [1:0] {
    REQ_OUTPUT    = 2'd0,
    REQ_REFERENCE = 2'd1,
    REQ_ERROR     = 2'd2
  } req_type_t;

  localparam int CFG_W = 14;
  localparam logic [CFG_W-1:0] CFG_RESET = 14'd100;

  // |error| is scaled by this before comparing against limit * |reference|
  localparam int THRESH_SCALE = 10000;

  // reset values: 1.0 and 10.0 in Q16.8; history/reference need 13 bits to hold them
  localparam int REF_RESET_VAL  = 256;
  localparam int HIST_RESET_VAL = 2560;
  localparam int HIST_MIN_W     = 13;

  localparam logic signed [1:0] STEP_TIGHTEN = 2'sb11;
  localparam logic signed [1:0] STEP_NONE    = 2'sb00;
  localparam logic signed [1:0] STEP_RELAX   = 2'sb01;

  typedef struct packed {
    logic signed [1:0] err_step;
    logic signed [1:0] derr_step;
    logic signed [1:0] dout_step;
  } gain_steps_t;

endpackage

// ===== hw/rtl/etgrt_fifo.sv =====
// Small register queue with fall-through read and occupancy count.
module etgrt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic                             pop,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/etgrt_front.sv =====
// Front end: takes tagged samples, keeps the sample state, queues error snapshots.
module etgrt_front #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [1:0]                        req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_value,
  input  logic                              cfg_wr_en,
  input  logic [etgrt_pkg::CFG_W-1:0]       cfg_wr_data,
  output logic [etgrt_pkg::CFG_W-1:0]       limit,
  output logic                              rec_push,
  output logic [4*SAMPLE_WIDTH+2+4*((SAMPLE_WIDTH > etgrt_pkg::HIST_MIN_W) ?
                SAMPLE_WIDTH : etgrt_pkg::HIST_MIN_W)-1:0] rec_data
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int HW = (W > etgrt_pkg::HIST_MIN_W) ? W : etgrt_pkg::HIST_MIN_W;

  logic [etgrt_pkg::CFG_W-1:0] limit_r;
  logic signed [HW-1:0]        ref_r, ref_nxt;
  logic signed [HW-1:0]        hist_r [3];
  logic signed [HW-1:0]        hist_nxt [3];
  logic signed [W-1:0]         err_now_r, err_now_nxt;
  logic signed [W:0]           err_chg_r, err_chg_nxt;
  logic signed [HW-1:0]        sample_ext;
  logic signed [W:0]           err_diff;
  logic                        is_err;

  assign sample_ext = HW'(sample_value);
  assign err_diff   = (W+1)'(sample_value) - (W+1)'(err_now_r);
  assign limit      = limit_r;

  always_comb begin
    ref_nxt     = ref_r;
    hist_nxt    = hist_r;
    err_now_nxt = err_now_r;
    err_chg_nxt = err_chg_r;
    is_err      = 1'b0;
    if (accept) begin
      case (etgrt_pkg::req_type_t'(req_type))
        etgrt_pkg::REQ_OUTPUT: begin
          hist_nxt[2] = hist_r[1];
          hist_nxt[1] = hist_r[0];
          hist_nxt[0] = sample_ext;
        end
        etgrt_pkg::REQ_REFERENCE: begin
          ref_nxt = sample_ext;
        end
        etgrt_pkg::REQ_ERROR: begin
          err_now_nxt = sample_value;
          err_chg_nxt = err_diff;
          is_err      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // snapshot: new error, previous error, new change, previous change, history, reference
  assign rec_push = is_err;
  assign rec_data = {sample_value, err_now_r, err_diff, err_chg_r,
                     hist_r[0], hist_r[1], hist_r[2], ref_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= etgrt_pkg::CFG_RESET;
      ref_r     <= HW'(etgrt_pkg::REF_RESET_VAL);
      hist_r[0] <= HW'(etgrt_pkg::HIST_RESET_VAL);
      hist_r[1] <= HW'(etgrt_pkg::HIST_RESET_VAL);
      hist_r[2] <= HW'(etgrt_pkg::HIST_RESET_VAL);
      err_now_r <= '0;
      err_chg_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      ref_r     <= ref_nxt;
      hist_r    <= hist_nxt;
      err_now_r <= err_now_nxt;
      err_chg_r <= err_chg_nxt;
    end
  end

endmodule

// ===== hw/rtl/etgrt_back.sv =====
// Back end: threshold products, rule evaluation and result push.
module etgrt_back #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int OUT_DEPTH    = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rec_valid,
  input  logic [4*SAMPLE_WIDTH+2+4*((SAMPLE_WIDTH > etgrt_pkg::HIST_MIN_W) ?
                SAMPLE_WIDTH : etgrt_pkg::HIST_MIN_W)-1:0] rec_data,
  output logic                              rec_pop,
  input  logic [etgrt_pkg::CFG_W-1:0]       limit,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]    res_count,
  output logic                              res_push,
  output etgrt_pkg::gain_steps_t            res_data
);

  localparam int W    = SAMPLE_WIDTH;
  localparam int HW   = (W > etgrt_pkg::HIST_MIN_W) ? W : etgrt_pkg::HIST_MIN_W;
  localparam int PE_W = W + etgrt_pkg::CFG_W;
  localparam int PR_W = HW + etgrt_pkg::CFG_W;
  localparam int CW   = $clog2(OUT_DEPTH+1);

  // unpacked snapshot
  logic signed [W-1:0]  r_e, r_p;
  logic signed [W:0]    r_d, r_dp;
  logic signed [HW-1:0] r_h0, r_h1, r_h2, r_ref;
  logic [W-1:0]         e_mag;
  logic [HW-1:0]        ref_mag;

  // stage 1 registers
  logic                 s1_v_r;
  logic signed [W-1:0]  s1_e_r, s1_p_r;
  logic signed [W:0]    s1_d_r, s1_dp_r;
  logic signed [HW:0]   s1_older_r, s1_newer_r;
  logic                 s1_h0nz_r;
  logic [PE_W-1:0]      s1_prod_e_r;
  logic [PR_W-1:0]      s1_prod_r_r;

  logic [CW:0]          used;
  logic                 p_pos, p_neg, e_pos, e_neg;
  logic                 exceed;
  etgrt_pkg::gain_steps_t steps;

  assign {r_e, r_p, r_d, r_dp, r_h0, r_h1, r_h2, r_ref} = rec_data;

  // reserve a result slot for every snapshot in flight
  assign used    = (CW+1)'(res_count) + (CW+1)'(s1_v_r);
  assign rec_pop = rec_valid && (used < (CW+1)'(OUT_DEPTH));

  assign e_mag   = r_e[W-1] ? (~r_e + 1'b1) : r_e;
  assign ref_mag = r_ref[HW-1] ? (~r_ref + 1'b1) : r_ref;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= rec_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_e_r      <= r_e;
      s1_p_r      <= r_p;
      s1_d_r      <= r_d;
      s1_dp_r     <= r_dp;
      s1_older_r  <= (HW+1)'(r_h1) - (HW+1)'(r_h2);
      s1_newer_r  <= (HW+1)'(r_h0) - (HW+1)'(r_h1);
      s1_h0nz_r   <= (r_h0 != '0);
      s1_prod_e_r <= PE_W'(e_mag) * PE_W'(etgrt_pkg::THRESH_SCALE);
      s1_prod_r_r <= PR_W'(limit) * PR_W'(ref_mag);
    end
  end

  assign p_neg  = s1_p_r[W-1];
  assign p_pos  = !s1_p_r[W-1] && (s1_p_r != '0);
  assign e_neg  = s1_e_r[W-1];
  assign e_pos  = !s1_e_r[W-1] && (s1_e_r != '0);
  assign exceed = PR_W'(s1_prod_e_r) > s1_prod_r_r;

  always_comb begin
    steps.err_step  = etgrt_pkg::STEP_NONE;
    steps.derr_step = etgrt_pkg::STEP_NONE;
    steps.dout_step = etgrt_pkg::STEP_NONE;

    // error rule: growing error tightens, sign crossing relaxes
    if ((p_pos && s1_e_r > s1_p_r) || (p_neg && s1_e_r < s1_p_r)) begin
      steps.err_step = etgrt_pkg::STEP_TIGHTEN;
    end else if ((p_pos && e_neg) || (p_neg && e_pos)) begin
      steps.err_step = etgrt_pkg::STEP_RELAX;
    end

    // error change rule
    if ((p_neg && s1_dp_r > 0 && s1_d_r < s1_dp_r) ||
        (p_pos && s1_dp_r < 0 && s1_d_r > s1_dp_r)) begin
      steps.derr_step = etgrt_pkg::STEP_TIGHTEN;
    end else if ((p_neg && s1_dp_r > 0 && e_pos && s1_d_r < 0) ||
                 (p_pos && s1_dp_r < 0 && e_neg && s1_d_r > 0)) begin
      steps.derr_step = etgrt_pkg::STEP_RELAX;
    end

    // output change rule
    if ((p_neg && s1_older_r > 0 && s1_newer_r < s1_older_r) ||
        (p_pos && s1_older_r < 0 && s1_newer_r > s1_older_r)) begin
      steps.dout_step = etgrt_pkg::STEP_TIGHTEN;
    end else if ((p_pos && s1_newer_r > 0 && e_neg) ||
                 (p_neg && s1_newer_r < 0 && e_pos)) begin
      steps.dout_step = etgrt_pkg::STEP_RELAX;
    end
  end

  assign res_data = steps;
  assign res_push = s1_v_r && s1_h0nz_r && exceed &&
                    ((steps.err_step != etgrt_pkg::STEP_NONE) ||
                     (steps.derr_step != etgrt_pkg::STEP_NONE) ||
                     (steps.dout_step != etgrt_pkg::STEP_NONE));

endmodule

// ===== hw/rtl/error_trend_gain_rule_tuner.sv =====
// Top level of the error trend gain rule tuner: front end, snapshot queue, back end, result queue.
// Error samples pass in order through the snapshot queue, stage 1 registers and the result queue.
// Throughput: one input and one result transaction per cycle while neither queue backs up.
// Rate is set by the back end's slot reservation against the OUT_DEPTH result queue.
// Reset (rst_n low, synchronous): queues empty, limit 100, reference 1.0, history 10.0, errors 0.
module error_trend_gain_rule_tuner #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int MID_DEPTH    = 2,
  parameter int OUT_DEPTH    = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [1:0]                      in_req_type,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample_value,
  // result channel
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [1:0]               out_error_gain_step,
  output logic signed [1:0]               out_delta_error_gain_step,
  output logic signed [1:0]               out_delta_output_gain_step,
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [etgrt_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int HW    = (W > etgrt_pkg::HIST_MIN_W) ? W : etgrt_pkg::HIST_MIN_W;
  // snapshot: two errors (W), two changes (W+1), three history taps and the reference (HW)
  localparam int REC_W = 4*W + 2 + 4*HW;
  localparam int RES_W = $bits(etgrt_pkg::gain_steps_t);
  localparam int OCW   = $clog2(OUT_DEPTH+1);

  logic                    in_accept;
  logic [etgrt_pkg::CFG_W-1:0] limit;

  // front -> snapshot queue -> back
  logic                    rec_push;
  logic [REC_W-1:0]        rec_wdata;
  logic [REC_W-1:0]        rec_rdata;
  logic                    rec_full;
  logic                    rec_empty;
  logic                    rec_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] rec_count;

  // back -> result queue
  logic                    res_push;
  etgrt_pkg::gain_steps_t  res_wdata;
  etgrt_pkg::gain_steps_t  res_rdata;
  logic                    res_full;
  logic [OCW-1:0]          res_count;

  // Every transaction type is held off while the snapshot queue is full, so that
  // state seen by a queued error snapshot is never overtaken out of order.
  assign in_full   = rec_full;
  assign in_accept = in_push && !rec_full;

  // Front: updates output history, reference and error state in the accept cycle;
  // an error sample drops a full snapshot of the state into the queue.
  etgrt_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .req_type     (in_req_type),
    .sample_value (in_sample_value),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .limit        (limit),
    .rec_push     (rec_push),
    .rec_data     (rec_wdata)
  );

  etgrt_fifo #(
    .WIDTH (REC_W),
    .DEPTH (MID_DEPTH)
  ) u_rec_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .pop   (rec_pop),
    .wdata (rec_wdata),
    .rdata (rec_rdata),
    .full  (rec_full),
    .empty (rec_empty),
    .count (rec_count)
  );

  // Back: stage 1 registers the two threshold products and output differences,
  // stage 2 compares, runs the three rule sets and pushes a result if any fired,
  // the threshold is exceeded and the newest output is nonzero. It only pulls a
  // snapshot when the result queue has a slot reserved for it, so the pipeline itself never stalls.
  etgrt_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .OUT_DEPTH    (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (!rec_empty && (rec_count != '0)),
    .rec_data  (rec_rdata),
    .rec_pop   (rec_pop),
    .limit     (limit),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  etgrt_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .pop   (out_pop),
    .wdata (res_wdata),
    .rdata (res_rdata),
    .full  (res_full),
    .empty (out_empty),
    .count (res_count)
  );

  assign out_error_gain_step        = res_rdata.err_step;
  assign out_delta_error_gain_step  = res_rdata.derr_step;
  // res_full never blocks a push (slots are reserved), it only gates the last field
  // through a mux that is constant in a correct design
  assign out_delta_output_gain_step = (res_full && out_empty) ? etgrt_pkg::STEP_NONE :
                                      res_rdata.dout_step;

endmodule

// ===== hw/rtl/etgrt_port_checker.sv =====
// Port-level checks for the error trend gain rule tuner, bound to the top level.
`include "error_trend_gain_rule_tuner_assert.svh"

module etgrt_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic signed [1:0] out_error_gain_step,
  input logic signed [1:0] out_delta_error_gain_step,
  input logic signed [1:0] out_delta_output_gain_step
);

  logic       any_step;
  logic       codes_ok;
  logic [5:0] out_steps;

  assign any_step  = (out_error_gain_step != etgrt_pkg::STEP_NONE) ||
                     (out_delta_error_gain_step != etgrt_pkg::STEP_NONE) ||
                     (out_delta_output_gain_step != etgrt_pkg::STEP_NONE);
  assign codes_ok  = (out_error_gain_step inside {etgrt_pkg::STEP_TIGHTEN,
                       etgrt_pkg::STEP_NONE, etgrt_pkg::STEP_RELAX}) &&
                     (out_delta_error_gain_step inside {etgrt_pkg::STEP_TIGHTEN,
                       etgrt_pkg::STEP_NONE, etgrt_pkg::STEP_RELAX}) &&
                     (out_delta_output_gain_step inside {etgrt_pkg::STEP_TIGHTEN,
                       etgrt_pkg::STEP_NONE, etgrt_pkg::STEP_RELAX});
  assign out_steps = {out_error_gain_step, out_delta_error_gain_step,
                      out_delta_output_gain_step};

  // reset leaves the result queue empty and the snapshot queue not full
  `ETGRT_ASSERT_NEXT(a_reset_clears, clk, 1'b0, !rst_n, out_empty && !in_full)

  // a result only exists when some rule fired
  `ETGRT_ASSERT_NOW(a_result_not_blank, clk, !rst_n, !out_empty, any_step)

  // steps are -1, 0 or +1 only
  `ETGRT_ASSERT_NOW(a_step_codes, clk, !rst_n, !out_empty, codes_ok)

  // a waiting result holds until taken
  `ETGRT_ASSERT_NEXT(a_result_holds, clk, !rst_n, !out_empty && !out_pop, !out_empty && $stable(out_steps))

endmodule

bind error_trend_gain_rule_tuner etgrt_port_checker u_port_checker (.*);
